@@ design/rts_pkg.sv @@
// ----------------------------------------------------------------------------
// rts_pkg: shared definitions for the ring thread scheduler
// Slot status codes, command codes, result codes and the result bundle.
// ----------------------------------------------------------------------------
package rts_pkg;

    localparam int CMD_W    = 3;
    localparam int SLOT_W   = 4;
    localparam int TID_W    = 16;
    localparam int STATUS_W = 2;
    localparam int CODE_W   = 2;

    // slot status
    localparam logic [STATUS_W-1:0] ST_FREE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_READY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RUNNING = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BLOCKED = 2'd3;

    // commands
    localparam logic [CMD_W-1:0] CMD_SCHEDULE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_BLOCK    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WAKE     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CREATE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_EXIT     = 3'd4;

    // result codes
    localparam logic [CODE_W-1:0] RC_OK          = 2'd0;
    localparam logic [CODE_W-1:0] RC_SELF_WOKEN  = 2'd1;
    localparam logic [CODE_W-1:0] RC_EXIT_REFUSE = 2'd2;
    localparam logic [CODE_W-1:0] RC_BAD_SLOT    = 2'd3;

    typedef struct packed {
        logic [CODE_W-1:0] status_code;
        logic              switched;
        logic [TID_W-1:0]  current_thread_id;
        logic [SLOT_W-1:0] current_slot;
    } rts_result_t;

endpackage

@@ design/rts_slot_mem.sv @@
// ----------------------------------------------------------------------------
// rts_slot_mem: slot table memory
// One write and one read port, registered read data. Per-entry valid bits
// stand in for the reset contents: slot 0 running, others free, all zero.
// ----------------------------------------------------------------------------
module rts_slot_mem #(
    parameter int SLOTS = 16,
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int EW = rts_pkg::STATUS_W + rts_pkg::TID_W + SW
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          rd_en,
    input  logic [SW-1:0] rd_addr,
    output logic [EW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [SW-1:0] wr_addr,
    input  logic [EW-1:0] wr_data
);

    logic [EW-1:0]    mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;
    logic [EW-1:0]    q_reg;
    logic             q_valid_reg;
    logic             q_zero_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            q_reg       <= mem[rd_addr];
            q_valid_reg <= valid_reg[rd_addr];
            q_zero_reg  <= (rd_addr == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // unwritten entry reads as its reset contents
    assign rd_data = q_valid_reg ? q_reg
                   : {(q_zero_reg ? rts_pkg::ST_RUNNING : rts_pkg::ST_FREE),
                      {rts_pkg::TID_W{1'b0}}, {SW{1'b0}}};

endmodule

@@ design/rts_seq.sv @@
// ----------------------------------------------------------------------------
// rts_seq: command sequencer
// Read-modify-write over the slot table; walks the ring one entry per cycle.
// ----------------------------------------------------------------------------
module rts_seq #(
    parameter int SLOTS = 16,
    localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int EW  = rts_pkg::STATUS_W + rts_pkg::TID_W + SW,
    localparam int STW = $clog2(SLOTS + 1),
    localparam int CW  = ((SW > rts_pkg::SLOT_W) ? SW : rts_pkg::SLOT_W) + 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // command in
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  logic [rts_pkg::CMD_W-1:0]    cmd,
    input  logic [rts_pkg::SLOT_W-1:0]   slot,
    input  logic [rts_pkg::TID_W-1:0]    thread_id,
    // result out
    output logic                         res_valid,
    input  logic                         res_ready,
    output rts_pkg::rts_result_t         res,
    // slot table
    output logic                         rd_en,
    output logic [SW-1:0]                rd_addr,
    input  logic [EW-1:0]                rd_data,
    output logic                         wr_en,
    output logic [SW-1:0]                wr_addr,
    output logic [EW-1:0]                wr_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CUR    = 4'd1;
    localparam logic [3:0] S_WALK   = 4'd2;
    localparam logic [3:0] S_FOUND  = 4'd3;
    localparam logic [3:0] S_TGT    = 4'd4;
    localparam logic [3:0] S_LINK   = 4'd5;
    localparam logic [3:0] S_PRED   = 4'd6;
    localparam logic [3:0] S_RDSUCC = 4'd7;
    localparam logic [3:0] S_SUCC   = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0]                     state_reg,   state_next;
    logic [SW-1:0]                  cur_reg,     cur_next;
    logic [rts_pkg::CMD_W-1:0]      cmd_reg,     cmd_next;
    logic [SW-1:0]                  slot_reg,    slot_next;
    logic                           bad_reg,     bad_next;
    logic [rts_pkg::TID_W-1:0]      tid_in_reg,  tid_in_next;
    logic [rts_pkg::STATUS_W-1:0]   cur_st_reg,  cur_st_next;
    logic [SW-1:0]                  cur_succ_reg, cur_succ_next;
    logic [rts_pkg::TID_W-1:0]      cur_tid_reg, cur_tid_next;
    logic [SW-1:0]                  probe_reg,   probe_next;
    logic [STW-1:0]                 step_reg,    step_next;
    logic [rts_pkg::CODE_W-1:0]     code_reg,    code_next;
    rts_pkg::rts_result_t           res_reg,     res_next;

    logic [rts_pkg::STATUS_W-1:0]   r_st;
    logic [rts_pkg::TID_W-1:0]      r_tid;
    logic [SW-1:0]                  r_succ;
    logic [rts_pkg::STATUS_W-1:0]   eff_st;
    logic [rts_pkg::STATUS_W-1:0]   fin_st;
    logic [CW-1:0]                  slot_ext;
    logic                           same;

    assign r_st   = rd_data[EW-1 -: rts_pkg::STATUS_W];
    assign r_tid  = rd_data[SW +: rts_pkg::TID_W];
    assign r_succ = rd_data[SW-1:0];
    assign slot_ext = CW'(slot);
    assign same   = (slot_reg == cur_reg);

    function automatic logic [rts_pkg::SLOT_W-1:0] out_slot(input logic [SW-1:0] s);
        logic [CW-1:0] e;
        e = CW'(s);
        return e[rts_pkg::SLOT_W-1:0];
    endfunction

    function automatic rts_pkg::rts_result_t mk_res(
        input logic [SW-1:0]                s,
        input logic [rts_pkg::TID_W-1:0]    t,
        input logic                         sw,
        input logic [rts_pkg::CODE_W-1:0]   c
    );
        rts_pkg::rts_result_t r;
        r.current_slot      = out_slot(s);
        r.current_thread_id = t;
        r.switched          = sw;
        r.status_code       = c;
        return r;
    endfunction

    always_comb begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        cmd_next      = cmd_reg;
        slot_next     = slot_reg;
        bad_next      = bad_reg;
        tid_in_next   = tid_in_reg;
        cur_st_next   = cur_st_reg;
        cur_succ_next = cur_succ_reg;
        cur_tid_next  = cur_tid_reg;
        probe_next    = probe_reg;
        step_next     = step_reg;
        code_next     = code_reg;
        res_next      = res_reg;
        rd_en         = 1'b0;
        rd_addr       = cur_reg;
        wr_en         = 1'b0;
        wr_addr       = cur_reg;
        wr_data       = '0;
        cmd_ready     = 1'b0;
        res_valid     = 1'b0;
        eff_st        = (cmd_reg == rts_pkg::CMD_BLOCK) ? rts_pkg::ST_BLOCKED : r_st;
        fin_st        = cur_st_reg;

        case (state_reg)
            S_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    cmd_next    = cmd;
                    bad_next    = (slot_ext >= CW'(SLOTS));
                    slot_next   = slot_ext[SW-1:0];
                    tid_in_next = thread_id;
                    rd_en       = 1'b1;
                    rd_addr     = cur_reg;
                    state_next  = S_CUR;
                end
            end

            S_CUR: begin
                cur_st_next   = eff_st;
                cur_succ_next = r_succ;
                cur_tid_next  = r_tid;
                code_next     = rts_pkg::RC_OK;
                case (cmd_reg)
                    rts_pkg::CMD_SCHEDULE, rts_pkg::CMD_BLOCK: begin
                        if (r_succ == cur_reg) begin
                            // lone thread: keep it, wake it if needed
                            if (eff_st == rts_pkg::ST_READY || eff_st == rts_pkg::ST_RUNNING) begin
                                fin_st   = eff_st;
                                res_next = mk_res(cur_reg, r_tid, 1'b0, rts_pkg::RC_OK);
                            end else begin
                                fin_st   = rts_pkg::ST_RUNNING;
                                res_next = mk_res(cur_reg, r_tid, 1'b0,
                                                  rts_pkg::RC_SELF_WOKEN);
                            end
                            wr_en      = 1'b1;
                            wr_addr    = cur_reg;
                            wr_data    = {fin_st, r_tid, r_succ};
                            state_next = S_DONE;
                        end else begin
                            probe_next = r_succ;
                            step_next  = STW'(1);
                            rd_en      = 1'b1;
                            rd_addr    = r_succ;
                            state_next = S_WALK;
                        end
                    end
                    rts_pkg::CMD_WAKE, rts_pkg::CMD_CREATE: begin
                        if (bad_reg) begin
                            res_next   = mk_res(cur_reg, r_tid, 1'b0, rts_pkg::RC_BAD_SLOT);
                            state_next = S_DONE;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = slot_reg;
                            state_next = S_TGT;
                        end
                    end
                    rts_pkg::CMD_EXIT: begin
                        if (r_tid == '0) begin
                            code_next  = rts_pkg::RC_EXIT_REFUSE;
                            rd_en      = 1'b1;
                            rd_addr    = r_succ;
                            state_next = S_SUCC;
                        end else if (r_succ == cur_reg) begin
                            // self-linked: unlink leaves the ring as is
                            rd_en      = 1'b1;
                            rd_addr    = r_succ;
                            state_next = S_SUCC;
                        end else begin
                            probe_next = r_succ;
                            step_next  = STW'(1);
                            rd_en      = 1'b1;
                            rd_addr    = r_succ;
                            state_next = S_PRED;
                        end
                    end
                    default: begin
                        res_next   = mk_res(cur_reg, r_tid, 1'b0, rts_pkg::RC_OK);
                        state_next = S_DONE;
                    end
                endcase
            end

            S_WALK: begin
                if (r_st == rts_pkg::ST_READY) begin
                    wr_en      = 1'b1;
                    wr_addr    = probe_reg;
                    wr_data    = {rts_pkg::ST_RUNNING, r_tid, r_succ};
                    res_next   = mk_res(probe_reg, r_tid, 1'b1, rts_pkg::RC_OK);
                    state_next = S_FOUND;
                end else if (r_succ == cur_reg || step_reg >= STW'(SLOTS)) begin
                    if (cur_st_reg == rts_pkg::ST_READY || cur_st_reg == rts_pkg::ST_RUNNING) begin
                        fin_st   = cur_st_reg;
                        res_next = mk_res(cur_reg, cur_tid_reg, 1'b0, rts_pkg::RC_OK);
                    end else begin
                        fin_st   = rts_pkg::ST_RUNNING;
                        res_next = mk_res(cur_reg, cur_tid_reg, 1'b0,
                                          rts_pkg::RC_SELF_WOKEN);
                    end
                    wr_en      = 1'b1;
                    wr_addr    = cur_reg;
                    wr_data    = {fin_st, cur_tid_reg, cur_succ_reg};
                    state_next = S_DONE;
                end else begin
                    probe_next = r_succ;
                    step_next  = step_reg + STW'(1);
                    rd_en      = 1'b1;
                    rd_addr    = r_succ;
                end
            end

            S_FOUND: begin
                // demote old current; blocked or ready keeps its status
                fin_st     = (cur_st_reg == rts_pkg::ST_RUNNING) ? rts_pkg::ST_READY
                                                                 : cur_st_reg;
                wr_en      = 1'b1;
                wr_addr    = cur_reg;
                wr_data    = {fin_st, cur_tid_reg, cur_succ_reg};
                cur_next   = probe_reg;
                state_next = S_DONE;
            end

            S_TGT: begin
                if (cmd_reg == rts_pkg::CMD_WAKE) begin
                    if (r_st == rts_pkg::ST_FREE) begin
                        res_next = mk_res(cur_reg, cur_tid_reg, 1'b0, rts_pkg::RC_BAD_SLOT);
                    end else begin
                        wr_en    = 1'b1;
                        wr_addr  = slot_reg;
                        wr_data  = {rts_pkg::ST_READY, r_tid, r_succ};
                        res_next = mk_res(cur_reg, cur_tid_reg, 1'b0, rts_pkg::RC_OK);
                    end
                    state_next = S_DONE;
                end else if (r_st != rts_pkg::ST_FREE) begin
                    res_next   = mk_res(cur_reg, cur_tid_reg, 1'b0, rts_pkg::RC_BAD_SLOT);
                    state_next = S_DONE;
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = slot_reg;
                    wr_data    = {rts_pkg::ST_READY, tid_in_reg, cur_succ_reg};
                    state_next = S_LINK;
                end
            end

            S_LINK: begin
                // link new slot in after current
                fin_st     = same ? rts_pkg::ST_READY : cur_st_reg;
                wr_en      = 1'b1;
                wr_addr    = cur_reg;
                wr_data    = {fin_st, (same ? tid_in_reg : cur_tid_reg), slot_reg};
                res_next   = mk_res(cur_reg, (same ? tid_in_reg : cur_tid_reg), 1'b0,
                                    rts_pkg::RC_OK);
                state_next = S_DONE;
            end

            S_PRED: begin
                if (r_succ == cur_reg) begin
                    wr_en      = 1'b1;
                    wr_addr    = probe_reg;
                    wr_data    = {r_st, r_tid, cur_succ_reg};
                    state_next = S_RDSUCC;
                end else if (step_reg < STW'(SLOTS - 1)) begin
                    probe_next = r_succ;
                    step_next  = step_reg + STW'(1);
                    rd_en      = 1'b1;
                    rd_addr    = r_succ;
                end else begin
                    state_next = S_RDSUCC;
                end
            end

            S_RDSUCC: begin
                rd_en      = 1'b1;
                rd_addr    = cur_succ_reg;
                state_next = S_SUCC;
            end

            S_SUCC: begin
                res_next   = mk_res(cur_succ_reg, r_tid, (cur_succ_reg != cur_reg), code_reg);
                cur_next   = cur_succ_reg;
                state_next = S_DONE;
            end

            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cur_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        slot_reg     <= slot_next;
        bad_reg      <= bad_next;
        tid_in_reg   <= tid_in_next;
        cur_st_reg   <= cur_st_next;
        cur_succ_reg <= cur_succ_next;
        cur_tid_reg  <= cur_tid_next;
        probe_reg    <= probe_next;
        step_reg     <= step_next;
        code_reg     <= code_next;
        res_reg      <= res_next;
    end

    assign res = res_reg;

endmodule

@@ design/ring_thread_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// ring_thread_scheduler_unit: round-robin thread scheduler over a slot ring
// Each command reads the current entry. Schedule/block walk the ring from it to
//   the next ready slot, wake reads and updates the target, create reads the
//   target and links it in after the current slot, exit walks the ring to unlink
//   the current slot unless refused or self-linked; spare codes change nothing.
//   One command in flight; the next word is taken after its result leaves.
// Reset: synchronous, active low; slot 0 running and current, others free.
// ----------------------------------------------------------------------------
module ring_thread_scheduler_unit #(
    parameter int SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // command words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [2:0] command, [6:3] slot, [22:7] thread_id
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [3:0] current_slot, [19:4] current_thread_id,
                                   // [20] switched, [22:21] status_code
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EW = rts_pkg::STATUS_W + rts_pkg::TID_W + SW;

    // table port
    logic          rd_en;
    logic [SW-1:0] rd_addr;
    logic [EW-1:0] rd_data;
    logic          wr_en;
    logic [SW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    // sequencer to output stage
    logic                 res_valid;
    logic                 res_ready;
    rts_pkg::rts_result_t res;

    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;

    // slot table: status, thread id, ring successor per slot
    rts_slot_mem #(
        .SLOTS   (SLOTS)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // command sequencer: read current entry, walk ring, write back
    rts_seq #(
        .SLOTS     (SLOTS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd       (s_tdata[2:0]),
        .slot      (s_tdata[6:3]),
        .thread_id (s_tdata[22:7]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // output register: sequencer goes back to idle while a word waits here
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= {1'b0, res.status_code, res.switched,
                            res.current_thread_id, res.current_slot};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ test/ring_thread_scheduler_unit_tb.sv @@
// ----------------------------------------------------------------------------
// ring_thread_scheduler_unit_tb: self-checking bench for the thread scheduler
// Drives command words with random gaps and result back-pressure. A local
// copy of the slot table predicts each result word at input acceptance, and
// the results are compared field by field in arrival order. The run covers
// corner commands, a random mix, a long output hold-off and a gap-free burst.
// ----------------------------------------------------------------------------
module ring_thread_scheduler_unit_tb;

    localparam int SLOTS        = 16;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int STALL_LIMIT  = 2000;  // cycles with no word moving
    localparam int DRAIN_CYCLES = SLOTS + 16;

    // command codes the block ignores
    localparam logic [rts_pkg::CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [rts_pkg::CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // [2:0] command, [6:3] slot, [22:7] thread_id
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // [3:0] current_slot, [19:4] current_thread_id,
                             // [20] switched, [22:21] status_code

    // shared run control
    bit idles_on;            // random gaps on both sides
    bit hold_request;        // ask receiver for one long hold-off
    int mismatches;
    int quiet_cycles;

    // predicted result words, oldest first
    rts_pkg::rts_result_t expected_outcomes[$];

    // local copy of the slot table
    logic [rts_pkg::STATUS_W-1:0] slot_state [SLOTS];
    logic [rts_pkg::SLOT_W-1:0]   ring_link  [SLOTS];
    logic [rts_pkg::TID_W-1:0]    owner_id   [SLOTS];
    logic [rts_pkg::SLOT_W-1:0]   cur_slot;

    ring_thread_scheduler_unit #(
        .SLOTS(SLOTS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Ring walk from the current slot to the first other ready slot.
    function automatic logic [rts_pkg::CODE_W-1:0] pick_next_thread();
        logic [rts_pkg::SLOT_W-1:0] here;
        logic [rts_pkg::SLOT_W-1:0] probe;
        here  = cur_slot;
        probe = here;
        for (int n = 0; n < SLOTS; n++) begin
            probe = ring_link[probe];
            if (probe == here)
                break;
            if (slot_state[probe] == rts_pkg::ST_READY) begin
                // only a running thread is demoted; blocked/ready keep status
                if (slot_state[here] == rts_pkg::ST_RUNNING)
                    slot_state[here] = rts_pkg::ST_READY;
                slot_state[probe] = rts_pkg::ST_RUNNING;
                cur_slot = probe;
                return rts_pkg::RC_OK;
            end
        end
        // nobody else ready: a blocked current thread wakes itself
        if (slot_state[here] != rts_pkg::ST_READY &&
            slot_state[here] != rts_pkg::ST_RUNNING) begin
            slot_state[here] = rts_pkg::ST_RUNNING;
            return rts_pkg::RC_SELF_WOKEN;
        end
        return rts_pkg::RC_OK;
    endfunction

    // Unlink the current slot (not an id-0 thread) through its predecessor, move to its successor.
    function automatic logic [rts_pkg::CODE_W-1:0] retire_current();
        logic [rts_pkg::SLOT_W-1:0] here;
        logic [rts_pkg::SLOT_W-1:0] succ;
        logic [rts_pkg::SLOT_W-1:0] walk;
        logic [rts_pkg::CODE_W-1:0] rc;
        here = cur_slot;
        succ = ring_link[here];
        rc   = rts_pkg::RC_OK;
        if (owner_id[here] == '0) begin
            rc = rts_pkg::RC_EXIT_REFUSE;  // main thread: switch, no unlink
        end else begin
            walk = here;
            for (int n = 0; n < SLOTS; n++) begin
                if (ring_link[walk] == here) begin
                    ring_link[walk] = succ;
                    break;
                end
                walk = ring_link[walk];
            end
        end
        cur_slot = succ;
        return rc;
    endfunction

    // Apply one command word to the table copy and return the result word.
    function automatic rts_pkg::rts_result_t apply_command(
        input logic [rts_pkg::CMD_W-1:0]  op,
        input logic [rts_pkg::SLOT_W-1:0] target,
        input logic [rts_pkg::TID_W-1:0]  ident
    );
        rts_pkg::rts_result_t       res;
        logic [rts_pkg::SLOT_W-1:0] prior;
        logic [rts_pkg::SLOT_W-1:0] after_prior;
        logic [rts_pkg::CODE_W-1:0] rc;
        prior = cur_slot;
        rc    = rts_pkg::RC_OK;
        case (op)
            rts_pkg::CMD_SCHEDULE: begin
                rc = pick_next_thread();
            end
            rts_pkg::CMD_BLOCK: begin
                slot_state[prior] = rts_pkg::ST_BLOCKED;
                rc = pick_next_thread();
            end
            rts_pkg::CMD_WAKE: begin
                if (slot_state[target] == rts_pkg::ST_FREE)
                    rc = rts_pkg::RC_BAD_SLOT;
                else
                    slot_state[target] = rts_pkg::ST_READY;
            end
            rts_pkg::CMD_CREATE: begin
                if (slot_state[target] != rts_pkg::ST_FREE) begin
                    rc = rts_pkg::RC_BAD_SLOT;
                end else begin
                    after_prior        = ring_link[prior];
                    slot_state[target] = rts_pkg::ST_READY;
                    owner_id[target]   = ident;
                    ring_link[target]  = after_prior;
                    ring_link[prior]   = target;
                end
            end
            rts_pkg::CMD_EXIT: begin
                rc = retire_current();
            end
            default: ;                    // spare codes: no effect
        endcase
        res.current_slot      = cur_slot;
        res.current_thread_id = owner_id[cur_slot];
        res.switched          = (cur_slot != prior);
        res.status_code       = rc;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one command word; called and returning at a falling edge.
    task automatic send_word(input logic [rts_pkg::CMD_W-1:0]  op,
                             input logic [rts_pkg::SLOT_W-1:0] target,
                             input logic [rts_pkg::TID_W-1:0]  ident);
        while (idles_on && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, ident, target, op};
        do
            @(posedge aclk);
        while (!s_tready);
        expected_outcomes.push_back(apply_command(op, target, ident));
        @(negedge aclk);
    endtask

    // Random slot that is free (or occupied), falling back to any slot.
    function automatic logic [rts_pkg::SLOT_W-1:0] pick_slot(input bit want_free);
        logic [rts_pkg::SLOT_W-1:0] cand;
        for (int n = 0; n < 4 * SLOTS; n++) begin
            cand = rts_pkg::SLOT_W'($urandom_range(SLOTS - 1));
            if ((slot_state[cand] == rts_pkg::ST_FREE) == want_free)
                return cand;
        end
        return rts_pkg::SLOT_W'($urandom_range(SLOTS - 1));
    endfunction

    // Mostly sensible commands on the live table, some noise.
    task automatic send_random_command();
        int                         roll;
        logic [rts_pkg::CMD_W-1:0]  op;
        logic [rts_pkg::SLOT_W-1:0] target;
        logic [rts_pkg::TID_W-1:0]  ident;
        roll  = $urandom_range(99);
        // a quarter of new threads get id 0 so they survive exit
        ident = ($urandom_range(3) == 0) ? '0 : rts_pkg::TID_W'($urandom);
        if (roll < 30)
            op = rts_pkg::CMD_SCHEDULE;
        else if (roll < 45)
            op = rts_pkg::CMD_BLOCK;
        else if (roll < 67)
            op = rts_pkg::CMD_WAKE;
        else if (roll < 85)
            op = rts_pkg::CMD_CREATE;
        else if (roll < 89)
            op = rts_pkg::CMD_EXIT;
        else if (roll < 93)
            op = rts_pkg::CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
        else
            op = rts_pkg::CMD_W'($urandom_range(7));
        if (op == rts_pkg::CMD_CREATE)
            target = pick_slot(1'b1);
        else if (op == rts_pkg::CMD_WAKE)
            target = pick_slot(1'b0);
        else
            target = rts_pkg::SLOT_W'($urandom_range(SLOTS - 1));
        // occasionally aim at any slot: busy create, wake of a free slot
        if ($urandom_range(9) == 0)
            target = rts_pkg::SLOT_W'($urandom_range(SLOTS - 1));
        send_word(op, target, ident);
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_request = 1'b0;
            end else begin
                m_tready <= !(idles_on && $urandom_range(99) < 23);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check
    // ------------------------------------------------------------------------
    task automatic check_field(input string                     label,
                               input logic [rts_pkg::TID_W-1:0] want,
                               input logic [rts_pkg::TID_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, label, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : outcome_check
        rts_pkg::rts_result_t got;
        rts_pkg::rts_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = rts_pkg::rts_result_t'(m_tdata[22:0]);
            if (expected_outcomes.size() == 0) begin
                $display("%0t: unexpected result word: expected none, actual %h",
                         $time, m_tdata);
                mismatches++;
            end else begin
                want = expected_outcomes.pop_front();
                check_field("current_slot", rts_pkg::TID_W'(want.current_slot),
                            rts_pkg::TID_W'(got.current_slot));
                check_field("current_thread_id", want.current_thread_id,
                            got.current_thread_id);
                check_field("switched", rts_pkg::TID_W'(want.switched),
                            rts_pkg::TID_W'(got.switched));
                check_field("status_code", rts_pkg::TID_W'(want.status_code),
                            rts_pkg::TID_W'(got.status_code));
            end
        end
    end

    // Watchdog: nothing moving on either side for too long ends the run.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Corner commands from the reset table, walked by hand.
    task automatic test_corner_commands();
        send_word(rts_pkg::CMD_SCHEDULE, 4'd0,  16'h0000);  // lone thread: no switch
        send_word(rts_pkg::CMD_BLOCK,    4'd0,  16'h0000);  // lone thread, self-woken
        send_word(rts_pkg::CMD_WAKE,     4'd5,  16'h0000);  // free slot: bad slot
        send_word(rts_pkg::CMD_WAKE,     4'd0,  16'h0000);  // current goes ready
        send_word(rts_pkg::CMD_SCHEDULE, 4'd0,  16'h0000);  // ready current, alone
        send_word(rts_pkg::CMD_CREATE,   4'd15, 16'hFFFF);
        send_word(rts_pkg::CMD_CREATE,   4'd15, 16'h1234);  // busy slot
        send_word(rts_pkg::CMD_CREATE,   4'd0,  16'h4321);  // busy: current slot
        send_word(rts_pkg::CMD_CREATE,   4'd1,  16'h0000);  // second id-0 thread
        send_word(rts_pkg::CMD_SCHEDULE, 4'd0,  16'h0000);  // switch
        send_word(rts_pkg::CMD_SCHEDULE, 4'd0,  16'h0000);
        send_word(rts_pkg::CMD_BLOCK,    4'd0,  16'h0000);  // block with others ready
        send_word(rts_pkg::CMD_WAKE,     4'd15, 16'h0000);  // wake a blocked thread
        send_word(rts_pkg::CMD_EXIT,     4'd0,  16'h0000);
        send_word(rts_pkg::CMD_CREATE,   4'd10, 16'h8001);
        send_word(rts_pkg::CMD_EXIT,     4'd0,  16'h0000);
        for (int op = int'(CMD_SPARE_FIRST); op <= int'(CMD_SPARE_LAST); op++)
            send_word(rts_pkg::CMD_W'(op), 4'd9, 16'hA5A5);
        send_word(rts_pkg::CMD_EXIT,     4'd0,  16'h0000);
        send_word(rts_pkg::CMD_SCHEDULE, 4'd0,  16'h0000);
        send_word(rts_pkg::CMD_BLOCK,    4'd0,  16'h0000);
        send_word(rts_pkg::CMD_WAKE,     4'd10, 16'h0000);
        send_word(rts_pkg::CMD_CREATE,   4'd7,  16'h7FFE);
        send_word(rts_pkg::CMD_EXIT,     4'd0,  16'h0000);
    endtask

    task automatic test_random_mix(input int count);
        idles_on = 1'b1;
        repeat (count) send_random_command();
    endtask

    // Receiver holds off while commands keep coming: input must stall.
    task automatic test_back_pressure();
        idles_on     = 1'b1;
        hold_request = 1'b1;
        repeat (40) send_random_command();
    endtask

    // Back-to-back words, no gaps on either side.
    task automatic test_steady_stream(input int count);
        idles_on = 1'b0;
        repeat (count) send_random_command();
        idles_on = 1'b1;
    endtask

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        idles_on     = 1'b0;
        hold_request = 1'b0;
        mismatches   = 0;
        quiet_cycles = 0;
        for (int n = 0; n < SLOTS; n++) begin
            slot_state[n] = rts_pkg::ST_FREE;
            ring_link[n]  = '0;
            owner_id[n]   = '0;
        end
        slot_state[0] = rts_pkg::ST_RUNNING;
        cur_slot      = '0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_corner_commands();
        test_random_mix(600);
        test_back_pressure();
        test_steady_stream(250);
        test_random_mix(340);

        s_tvalid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge aclk);
        // catch any stray word after the last expected one
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
design/rts_pkg.sv
design/rts_slot_mem.sv
design/rts_seq.sv
design/ring_thread_scheduler_unit.sv
test/ring_thread_scheduler_unit_tb.sv
